FILE: hdl/lgts_pkg.sv
// ----------------------------------------------------------------------------
// lgts_pkg
// Shared types, sizes and helpers for the LDA Gibbs topic sampler.
// ----------------------------------------------------------------------------
package lgts_pkg;

  // Table sizes
  localparam int TOPIC_COUNT = 16;
  localparam int DOC_COUNT   = 1024;
  localparam int TERM_COUNT  = 4096;
  localparam int NUM_TOKENS  = 65536;

  localparam int TOPIC_W = $clog2(TOPIC_COUNT);
  localparam int KACT_W  = TOPIC_W + 1;
  localparam int DOC_AW  = $clog2(DOC_COUNT);
  localparam int TERM_AW = $clog2(TERM_COUNT);
  localparam int TOK_AW  = $clog2(NUM_TOKENS);
  localparam int CLR_AW  = (DOC_AW > TERM_AW) ? DOC_AW : TERM_AW;

  // Arithmetic widths
  localparam int CNT_W  = 17;
  localparam int PRI_W  = 24;
  localparam int BT_W   = 32;
  localparam int DRAW_W = 16;
  localparam int FRAC_W = 16;
  localparam int OPD_W  = CNT_W + FRAC_W + 1;    // a, b and d
  localparam int NUM_W  = OPD_W + FRAC_W;        // b << 16
  localparam int Q_W    = 29;                    // ratio bits
  localparam int DSH_W  = OPD_W + Q_W - 1;       // divisor at top step
  localparam int PROD_W = OPD_W + Q_W;
  localparam int WGT_W  = PROD_W - FRAC_W;
  localparam int SUM_W  = WGT_W + TOPIC_W;
  localparam int TACC_W = SUM_W + DRAW_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Operation codes
  localparam logic OP_INIT     = 1'b0;
  localparam logic OP_RESAMPLE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BTOTAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [9:0]  doc_index;
    logic [11:0] term_id;
    logic [15:0] token_slot;
    logic [15:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic [3:0] new_topic;
    logic [3:0] old_topic;
  } out_item_t;

  // Sequencer controls broadcast to every cell
  typedef struct packed {
    logic               clr_en;
    logic [CLR_AW-1:0]  clr_addr;
    logic               rd_en;
    logic [DOC_AW-1:0]  rd_doc;
    logic [TERM_AW-1:0] rd_term;
    logic               load;
    logic               resample;
    logic [TOPIC_W-1:0] old_topic;
    logic               prep;
    logic               div_en;
    logic               sum_en;
    logic               cmp_en;
    logic [SUM_W-1:0]   target;
    logic               wr_en;
    logic [TOPIC_W-1:0] new_topic;
    logic [DOC_AW-1:0]  wr_doc;
    logic [TERM_AW-1:0] wr_term;
    logic [PRI_W-1:0]   alpha;
    logic [PRI_W-1:0]   beta;
    logic [BT_W-1:0]    beta_total;
    logic [KACT_W-1:0]  kact;
  } cell_ctl_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    cnt_inc = (c == COUNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
    cnt_dec = (c == '0) ? c : c - CNT_W'(1);
  endfunction

endpackage

FILE: hdl/lda_gibbs_topic_sampler_core.sv
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler_core
// Collapsed Gibbs topic sampler: one token per item, a row of topic cells.
// ----------------------------------------------------------------------------
// Initialize items go from accept through the load and write-back states to the
//   result register; resample items also pass the prep state, the bit-serial
//   divide-multiply, the prefix chain, the serial target multiply, compare and pick.
// One item at a time: no item is accepted until the last is written back, and a
//   result stall holds the write-back. Reset: synchronous, active low; then a
//   clearing pass over the longer count column during which no item is accepted.
module lda_gibbs_topic_sampler_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lgts_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lgts_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [lgts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_PREP  = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_SUM   = 4'd5;
  localparam logic [3:0] ST_TGT   = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_PICK  = 4'd8;
  localparam logic [3:0] ST_WRITE = 4'd9;

  localparam int NT = lgts_pkg::TOPIC_COUNT;

  logic [3:0]                    state_r, state_nxt;
  logic [lgts_pkg::CLR_AW-1:0]   clr_r;
  logic [4:0]                    step_r;
  logic [lgts_pkg::PRI_W-1:0]    alpha_r, beta_r;
  logic [lgts_pkg::BT_W-1:0]     btotal_r;
  logic [4:0]                    active_r;
  lgts_pkg::in_item_t            item_r;
  logic [lgts_pkg::TOPIC_W-1:0]  tok_mem [lgts_pkg::NUM_TOKENS];
  logic [lgts_pkg::TOPIC_W-1:0]  tok_rd_r;
  logic [lgts_pkg::TOPIC_W-1:0]  old_r, new_r, new_nxt;
  logic [lgts_pkg::TACC_W-1:0]   tacc_r;
  logic                          out_valid_r;
  lgts_pkg::out_item_t           out_r;

  logic                          accept, wr_go;
  logic [lgts_pkg::KACT_W-1:0]   kact;
  logic [20:0]                   uni_prod;
  logic [lgts_pkg::TOPIC_W-1:0]  uni_topic, pick_topic;
  logic [lgts_pkg::SUM_W-1:0]    sum_all;
  lgts_pkg::cell_ctl_t           ctl;
  logic [lgts_pkg::SUM_W-1:0]    prefix [NT+1];
  logic [NT-1:0]                 gt;

  assign accept = in_valid && !in_stall;
  assign wr_go  = (state_r == ST_WRITE) && (!out_valid_r || !out_stall);

  // Clamp active topic count into 1..TOPIC_COUNT
  always_comb begin
    if (active_r == '0) begin
      kact = lgts_pkg::KACT_W'(1);
    end else if (lgts_pkg::KACT_W'(active_r) > lgts_pkg::KACT_W'(NT)) begin
      kact = lgts_pkg::KACT_W'(NT);
    end else begin
      kact = lgts_pkg::KACT_W'(active_r);
    end
  end

  assign uni_prod  = item_r.random_draw * 21'(kact);
  assign uni_topic = lgts_pkg::TOPIC_W'(uni_prod[20:16]);
  assign sum_all   = prefix[NT];

  // First topic whose running sum exceeds the target
  always_comb begin
    pick_topic = lgts_pkg::TOPIC_W'(kact - lgts_pkg::KACT_W'(1));
    for (int i = NT - 1; i >= 0; i--) begin
      if (gt[i]) begin
        pick_topic = lgts_pkg::TOPIC_W'(i);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= 24'd65536;
      beta_r   <= 24'd6554;
      btotal_r <= 32'd26843545;
      active_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        lgts_pkg::CFG_ALPHA:  alpha_r  <= cfg_wdata[23:0];
        lgts_pkg::CFG_BETA:   beta_r   <= cfg_wdata[23:0];
        lgts_pkg::CFG_BTOTAL: btotal_r <= cfg_wdata;
        lgts_pkg::CFG_ACTIVE: active_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    new_nxt   = new_r;
    case (state_r)
      ST_CLEAR: if (clr_r == lgts_pkg::CLR_AW'((1 << lgts_pkg::CLR_AW) - 1)) begin
        state_nxt = ST_IDLE;
      end
      ST_IDLE:  if (accept) begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (item_r.operation == lgts_pkg::OP_RESAMPLE) begin
          state_nxt = ST_PREP;
        end else begin
          new_nxt   = uni_topic;
          state_nxt = ST_WRITE;
        end
      end
      ST_PREP:  state_nxt = ST_DIV;
      ST_DIV:   if (step_r == 5'(lgts_pkg::Q_W - 1)) begin
        state_nxt = ST_SUM;
      end
      ST_SUM:   if (step_r == 5'(NT - 1)) begin
        state_nxt = ST_TGT;
      end
      ST_TGT:   if (step_r == 5'(lgts_pkg::DRAW_W - 1)) begin
        state_nxt = ST_CMP;
      end
      ST_CMP:   state_nxt = ST_PICK;
      ST_PICK: begin
        new_nxt   = (sum_all == '0) ? uni_topic : pick_topic;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: if (wr_go) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + lgts_pkg::CLR_AW'(1);
      end
      step_r <= (state_nxt != state_r) ? '0 : step_r + 5'd1;
    end
  end

  // Item, topic and target accumulator registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    new_r <= new_nxt;
    if (state_r == ST_LOAD) begin
      old_r <= (item_r.operation == lgts_pkg::OP_RESAMPLE) ? tok_rd_r : '0;
    end
    // Multiply the sum by the draw, most significant draw bit first
    if (state_r == ST_SUM) begin
      tacc_r <= '0;
    end else if (state_r == ST_TGT) begin
      tacc_r <= (tacc_r << 1) +
                (item_r.random_draw[~step_r[3:0]] ? lgts_pkg::TACC_W'(sum_all) : '0);
    end
  end

  // Token topic store
  always_ff @(posedge clk) begin
    if (wr_go) begin
      tok_mem[item_r.token_slot] <= new_r;
    end
    if (accept) begin
      tok_rd_r <= tok_mem[in_data.token_slot];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_r.new_topic <= new_r;
      out_r.old_topic <= old_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Broadcast controls
  always_comb begin
    ctl.clr_en     = (state_r == ST_CLEAR);
    ctl.clr_addr   = clr_r;
    ctl.rd_en      = accept;
    ctl.rd_doc     = in_data.doc_index;
    ctl.rd_term    = in_data.term_id;
    ctl.load       = (state_r == ST_LOAD);
    ctl.resample   = (item_r.operation == lgts_pkg::OP_RESAMPLE);
    ctl.old_topic  = (state_r == ST_LOAD) ? tok_rd_r : old_r;
    ctl.prep       = (state_r == ST_PREP);
    ctl.div_en     = (state_r == ST_DIV);
    ctl.sum_en     = (state_r == ST_SUM);
    ctl.cmp_en     = (state_r == ST_CMP);
    ctl.target     = tacc_r[lgts_pkg::TACC_W-1:lgts_pkg::DRAW_W];
    ctl.wr_en      = wr_go;
    ctl.new_topic  = new_r;
    ctl.wr_doc     = item_r.doc_index;
    ctl.wr_term    = item_r.term_id;
    ctl.alpha      = alpha_r;
    ctl.beta       = beta_r;
    ctl.beta_total = btotal_r;
    ctl.kact       = kact;
  end

  // Row of topic cells; the running sum moves one cell per cycle
  assign prefix[0] = '0;

  for (genvar g = 0; g < NT; g++) begin : g_cell
    lgts_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prefix_in  (prefix[g]),
      .prefix_out (prefix[g+1]),
      .gt_out     (gt[g])
    );
  end

  // Checks
  a_accept_idle : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == ST_IDLE)
    else $error("item accepted outside idle");

  a_result_from_write : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_WRITE)
    else $error("result appeared without a write-back");

  a_topic_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> lgts_pkg::KACT_W'(new_r) < kact)
    else $error("new topic beyond the active count");

endmodule

FILE: hdl/lgts_cell.sv
// ----------------------------------------------------------------------------
// lgts_cell
// One topic: its total, its document and term count columns, a bit-serial
// divide-multiply for the weight, and one stage of the prefix-sum chain.
// ----------------------------------------------------------------------------
module lgts_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lgts_pkg::cell_ctl_t           ctl,
  input  logic [lgts_pkg::SUM_W-1:0]    prefix_in,
  output logic [lgts_pkg::SUM_W-1:0]    prefix_out,
  output logic                          gt_out
);

  localparam logic [lgts_pkg::TOPIC_W-1:0] MY_TOPIC = lgts_pkg::TOPIC_W'(CELL_IDX);

  logic [lgts_pkg::CNT_W-1:0] doc_mem  [lgts_pkg::DOC_COUNT];
  logic [lgts_pkg::CNT_W-1:0] word_mem [lgts_pkg::TERM_COUNT];

  logic [lgts_pkg::CNT_W-1:0]  doc_rd_r, word_rd_r;
  logic [lgts_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [lgts_pkg::CNT_W-1:0]  dc_r, wc_r;
  logic [lgts_pkg::OPD_W-1:0]  a_r;
  logic [lgts_pkg::NUM_W-1:0]  rem_r, rem_nxt;
  logic [lgts_pkg::DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [lgts_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                        sat_r;
  logic [lgts_pkg::SUM_W-1:0]  prefix_r;
  logic                        gt_r;

  logic                        is_old, is_new, active;
  logic [lgts_pkg::OPD_W-1:0]  a_val, b_val, d_val;
  logic [lgts_pkg::NUM_W-1:0]  num_val;
  logic                        sat_val, fits, qbit;
  logic [lgts_pkg::WGT_W-1:0]  weight;
  logic [lgts_pkg::CNT_W-1:0]  dc_wr, wc_wr;
  logic                        mem_wr;

  assign is_old = ctl.resample && (ctl.old_topic == MY_TOPIC);
  assign is_new = (ctl.new_topic == MY_TOPIC);
  assign active = (lgts_pkg::KACT_W'(CELL_IDX) < ctl.kact);

  // Form the Q16 operands of the weight
  assign a_val   = lgts_pkg::OPD_W'(ctl.alpha) + lgts_pkg::OPD_W'({dc_r, 16'b0});
  assign b_val   = lgts_pkg::OPD_W'(ctl.beta) + lgts_pkg::OPD_W'({wc_r, 16'b0});
  assign d_val   = lgts_pkg::OPD_W'(ctl.beta_total) + lgts_pkg::OPD_W'({total_r, 16'b0});
  assign num_val = {b_val, 16'b0};
  // Ratio of 2^29 or more (or a zero divisor) saturates
  assign sat_val = (lgts_pkg::PROD_W'(num_val) >=
                    lgts_pkg::PROD_W'({d_val, {lgts_pkg::Q_W{1'b0}}}));

  // One quotient bit per cycle, fed straight into a shift-add multiply
  assign fits     = (lgts_pkg::DSH_W'(rem_r) >= dsh_r);
  assign qbit     = sat_r || fits;
  assign rem_nxt  = (!sat_r && fits) ? rem_r - dsh_r[lgts_pkg::NUM_W-1:0] : rem_r;
  assign dsh_nxt  = dsh_r >> 1;
  assign prod_nxt = (prod_r << 1) + (qbit ? lgts_pkg::PROD_W'(a_r) : '0);
  assign weight   = prod_r[lgts_pkg::PROD_W-1:lgts_pkg::FRAC_W];

  // Final counts written back for this item
  assign mem_wr    = ctl.wr_en && (is_new || is_old);
  assign dc_wr     = is_new ? lgts_pkg::cnt_inc(dc_r) : dc_r;
  assign wc_wr     = is_new ? lgts_pkg::cnt_inc(wc_r) : wc_r;
  assign total_nxt = (ctl.wr_en && is_new) ? lgts_pkg::cnt_inc(total_r) :
                     (ctl.load && is_old) ? lgts_pkg::cnt_dec(total_r) : total_r;

  // Count columns: clear sweep, registered read, write-back
  always_ff @(posedge clk) begin
    if (ctl.clr_en) begin
      if (ctl.clr_addr < lgts_pkg::CLR_AW'(lgts_pkg::DOC_COUNT)) begin
        doc_mem[ctl.clr_addr[lgts_pkg::DOC_AW-1:0]] <= '0;
      end
      if (ctl.clr_addr < lgts_pkg::CLR_AW'(lgts_pkg::TERM_COUNT)) begin
        word_mem[ctl.clr_addr[lgts_pkg::TERM_AW-1:0]] <= '0;
      end
    end else if (mem_wr) begin
      doc_mem[ctl.wr_doc]   <= dc_wr;
      word_mem[ctl.wr_term] <= wc_wr;
    end
    if (ctl.rd_en) begin
      doc_rd_r  <= doc_mem[ctl.rd_doc];
      word_rd_r <= word_mem[ctl.rd_term];
    end
  end

  // Topic total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dc_r <= is_old ? lgts_pkg::cnt_dec(doc_rd_r) : doc_rd_r;
      wc_r <= is_old ? lgts_pkg::cnt_dec(word_rd_r) : word_rd_r;
    end
    if (ctl.prep) begin
      a_r    <= a_val;
      rem_r  <= num_val;
      dsh_r  <= lgts_pkg::DSH_W'({d_val, {(lgts_pkg::Q_W-1){1'b0}}});
      sat_r  <= sat_val;
      prod_r <= '0;
    end else if (ctl.div_en) begin
      rem_r  <= rem_nxt;
      dsh_r  <= dsh_nxt;
      prod_r <= prod_nxt;
    end
    if (ctl.sum_en) begin
      prefix_r <= prefix_in + (active ? lgts_pkg::SUM_W'(weight) : '0);
    end
    if (ctl.cmp_en) begin
      gt_r <= (prefix_r > ctl.target);
    end
  end

  assign prefix_out = prefix_r;
  assign gt_out     = gt_r;

endmodule

FILE: tb/tb_lda_gibbs_topic_sampler_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lda_gibbs_topic_sampler_core
// Checks the Gibbs topic sampler item by item against a behavioral predictor
// that keeps its own count tables, slot store and prior registers.
// ----------------------------------------------------------------------------
module tb_lda_gibbs_topic_sampler_core;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int NTOP = lgts_pkg::TOPIC_COUNT;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lgts_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lgts_pkg::out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [lgts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  lda_gibbs_topic_sampler_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [23:0] p_alpha = 24'd65536;
  logic [23:0] p_beta = 24'd6554;
  logic [31:0] p_btotal = 32'd26843545;
  logic [4:0]  p_active = 5'd16;
  logic [16:0] tot_cnt [NTOP];
  logic [16:0] doc_cnt [lgts_pkg::DOC_COUNT][NTOP];
  logic [16:0] word_cnt [lgts_pkg::TERM_COUNT][NTOP];
  logic [3:0]  slot_topic [int];

  lgts_pkg::out_item_t topic_queue[$];
  int errors = 0;
  int accepted = 0;
  int results = 0;
  int resamples = 0;
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  bit done = 0;

  function automatic logic [16:0] sat_up(logic [16:0] c);
    return (c == 17'h1FFFF) ? c : c + 17'd1;
  endfunction

  function automatic logic [16:0] sat_down(logic [16:0] c);
    return (c == 17'd0) ? c : c - 17'd1;
  endfunction

  // Work out the topic result for one item and update the tables
  function automatic lgts_pkg::out_item_t sample_topic(lgts_pkg::in_item_t it);
    lgts_pkg::out_item_t r;
    int unsigned kact;
    logic [63:0] w [NTOP];
    logic [63:0] a, b, d, q, sum, target, run;
    logic [3:0] oldt, newt;
    oldt = 4'd0;
    kact = (p_active == 0) ? 1 : (p_active > NTOP ? NTOP : p_active);
    if (it.operation == lgts_pkg::OP_INIT) begin
      newt = 4'((64'(it.random_draw) * kact) >> 16);
    end else begin
      oldt = slot_topic[it.token_slot];
      tot_cnt[oldt] = sat_down(tot_cnt[oldt]);
      doc_cnt[it.doc_index][oldt] = sat_down(doc_cnt[it.doc_index][oldt]);
      word_cnt[it.term_id][oldt] = sat_down(word_cnt[it.term_id][oldt]);
      sum = 0;
      for (int k = 0; k < kact; k++) begin
        a = 64'(p_alpha) + (64'(doc_cnt[it.doc_index][k]) << 16);
        b = 64'(p_beta) + (64'(word_cnt[it.term_id][k]) << 16);
        d = 64'(p_btotal) + (64'(tot_cnt[k]) << 16);
        if (d == 0) q = 64'd536870911;
        else begin
          q = (b << 16) / d;
          if (q > 64'd536870911) q = 64'd536870911;
        end
        w[k] = (a * q) >> 16;
        sum += w[k];
      end
      if (sum == 0) begin
        newt = 4'((64'(it.random_draw) * kact) >> 16);
      end else begin
        target = (sum >> 16) * it.random_draw + (((sum & 64'hFFFF) * it.random_draw) >> 16);
        newt = 4'(kact - 1);
        run = 0;
        for (int k = 0; k < kact; k++) begin
          run += w[k];
          if (run > target) begin
            newt = 4'(k);
            break;
          end
        end
      end
    end
    slot_topic[it.token_slot] = newt;
    tot_cnt[newt] = sat_up(tot_cnt[newt]);
    doc_cnt[it.doc_index][newt] = sat_up(doc_cnt[it.doc_index][newt]);
    word_cnt[it.term_id][newt] = sat_up(word_cnt[it.term_id][newt]);
    r.new_topic = newt;
    r.old_topic = oldt;
    return r;
  endfunction

  // Directed stimulus table; expected topics filled only for plain cases
  typedef struct {
    lgts_pkg::in_item_t  item;
    bit                  has_exp;
    lgts_pkg::out_item_t exp;
  } dir_row_t;
  dir_row_t dir_rows[$];

  task automatic add_row(logic op, int doc, int term, int slot, int draw,
                         bit has_exp = 0, int nt = 0, int ot = 0);
    dir_row_t r;
    r.item = '{operation: op, doc_index: 10'(doc), term_id: 12'(term),
               token_slot: 16'(slot), random_draw: 16'(draw)};
    r.has_exp = has_exp;
    r.exp = '{new_topic: 4'(nt), old_topic: 4'(ot)};
    dir_rows.push_back(r);
  endtask

  task automatic write_reg(logic [lgts_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lgts_pkg::CFG_ALPHA:  p_alpha = val[23:0];
      lgts_pkg::CFG_BETA:   p_beta = val[23:0];
      lgts_pkg::CFG_BTOTAL: p_btotal = val;
      lgts_pkg::CFG_ACTIVE: p_active = val[4:0];
      default: ;
    endcase
  endtask

  // Send one item; predict when it is accepted. Valid stays high after the
  // accept so that back-to-back items need no gap.
  task automatic send_item(lgts_pkg::in_item_t it, bit has_exp = 0,
                           lgts_pkg::out_item_t exp = '0);
    lgts_pkg::out_item_t pr;
    while (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pr = sample_topic(it);
    if (has_exp && pr !== exp) begin
      $error("directed row: table new_topic %0d old_topic %0d, predictor %0d %0d",
             exp.new_topic, exp.old_topic, pr.new_topic, pr.old_topic);
      errors++;
    end
    topic_queue.push_back(pr);
    accepted++;
    if (it.operation == lgts_pkg::OP_RESAMPLE) resamples++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (topic_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random token set: small pools of docs, terms and slots for deep counts
  int slot_pool[$];
  task automatic random_items(int n);
    lgts_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.doc_index = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(7));
      it.term_id = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
      it.random_draw = 16'($urandom);
      if (slot_pool.size() == 0 || $urandom_range(4) == 0) begin
        it.operation = lgts_pkg::OP_INIT;
        it.token_slot = 16'($urandom);
        if (!slot_topic.exists(it.token_slot)) slot_pool.push_back(it.token_slot);
      end else begin
        it.operation = lgts_pkg::OP_RESAMPLE;
        it.token_slot = 16'(slot_pool[$urandom_range(slot_pool.size() - 1)]);
      end
      send_item(it);
    end
  endtask

  // Receiver stall and checking of results
  always @(posedge clk) begin
    lgts_pkg::out_item_t want;
    if (rst_n) out_stall <= (idle_out_pct > 0) && ($urandom_range(99) < idle_out_pct);
    if (rst_n && out_valid && !out_stall) begin
      results++;
      if (topic_queue.size() == 0) begin
        $error("result with nothing expected: new_topic %0d old_topic %0d",
               out_data.new_topic, out_data.old_topic);
        errors++;
      end else begin
        want = topic_queue.pop_front();
        if (out_data.new_topic !== want.new_topic) begin
          $error("new_topic expected %0d actual %0d", want.new_topic, out_data.new_topic);
          errors++;
        end
        if (out_data.old_topic !== want.old_topic) begin
          $error("old_topic expected %0d actual %0d", want.old_topic, out_data.old_topic);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || cfg_we)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG_LIMIT && !done) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NTOP; k++) begin
      tot_cnt[k] = '0;
      for (int d = 0; d < lgts_pkg::DOC_COUNT; d++) doc_cnt[d][k] = '0;
      for (int t = 0; t < lgts_pkg::TERM_COUNT; t++) word_cnt[t][k] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: init extremes, resample of each, uniform fallback
    add_row(lgts_pkg::OP_INIT, 0, 0, 0, 0, 1, 0, 0);
    add_row(lgts_pkg::OP_INIT, 1023, 4095, 65535, 65535, 1, 15, 0);
    add_row(lgts_pkg::OP_INIT, 5, 7, 100, 32768, 1, 8, 0);
    add_row(lgts_pkg::OP_INIT, 5, 7, 101, 4096, 1, 1, 0);
    add_row(lgts_pkg::OP_RESAMPLE, 0, 0, 0, 0);
    add_row(lgts_pkg::OP_RESAMPLE, 1023, 4095, 65535, 65535);
    add_row(lgts_pkg::OP_RESAMPLE, 5, 7, 100, 32768);
    add_row(lgts_pkg::OP_RESAMPLE, 5, 7, 101, 12345);
    add_row(lgts_pkg::OP_RESAMPLE, 5, 7, 100, 65535);
    add_row(lgts_pkg::OP_INIT, 682, 2730, 43690, 43690, 1, 10, 0);
    add_row(lgts_pkg::OP_INIT, 341, 1365, 21845, 21845, 1, 5, 0);
    add_row(lgts_pkg::OP_RESAMPLE, 682, 2730, 43690, 1);
    add_row(lgts_pkg::OP_RESAMPLE, 341, 1365, 21845, 65534);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);
    wait_drained();

    // Stale topics and zero weights: shrink active set, zero priors
    write_reg(lgts_pkg::CFG_ACTIVE, 32'd3);
    write_reg(lgts_pkg::CFG_ALPHA, 32'd0);
    write_reg(lgts_pkg::CFG_BETA, 32'd0);
    send_item('{lgts_pkg::OP_RESAMPLE, 10'd1023, 12'd4095, 16'd65535, 16'd40000}); // stale slot
    send_item('{lgts_pkg::OP_RESAMPLE, 10'd900, 12'd3000, 16'd0, 16'd50000});      // all zero
    wait_drained();
    write_reg(lgts_pkg::CFG_BTOTAL, 32'd0);
    write_reg(lgts_pkg::CFG_ALPHA, 32'hFFFFFF);
    write_reg(lgts_pkg::CFG_BETA, 32'hFFFFFF);
    write_reg(lgts_pkg::CFG_ACTIVE, 32'd0);
    send_item('{lgts_pkg::OP_RESAMPLE, 10'd5, 12'd7, 16'd100, 16'd30000});
    send_item('{lgts_pkg::OP_INIT, 10'd5, 12'd7, 16'd102, 16'd65535});
    wait_drained();
    write_reg(lgts_pkg::CFG_ACTIVE, 32'd31);
    write_reg(lgts_pkg::CFG_BTOTAL, 32'hFFFFFFFF);
    send_item('{lgts_pkg::OP_RESAMPLE, 10'd5, 12'd7, 16'd101, 16'd777});
    wait_drained();

    // Random phases across settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_in_pct = 0;  idle_out_pct = 0;  end
        1: begin idle_in_pct = 68; idle_out_pct = 0;  end
        2: begin idle_in_pct = 0;  idle_out_pct = 68; end
        default: begin idle_in_pct = 23; idle_out_pct = 23; end
      endcase
      wait_drained();
      case (ph)
        0: begin write_reg(lgts_pkg::CFG_ALPHA, 32'd65536); write_reg(lgts_pkg::CFG_BETA, 32'd6554);
                 write_reg(lgts_pkg::CFG_BTOTAL, 32'd26843545);
                 write_reg(lgts_pkg::CFG_ACTIVE, 32'd16); end
        2: begin write_reg(lgts_pkg::CFG_ACTIVE, 32'd1); end
        3: begin write_reg(lgts_pkg::CFG_ACTIVE, 32'($urandom_range(2, 15)));
                 write_reg(lgts_pkg::CFG_ALPHA, 32'($urandom_range(1, 200000))); end
        5: begin write_reg(lgts_pkg::CFG_ACTIVE, 32'd16); write_reg(lgts_pkg::CFG_BETA, 32'd1);
                 write_reg(lgts_pkg::CFG_BTOTAL, 32'd4096); end
        6: begin write_reg(lgts_pkg::CFG_ALPHA, 32'd1); write_reg(lgts_pkg::CFG_ACTIVE, 32'd2); end
        default: ;
      endcase
      random_items(165);
    end
    idle_in_pct = 0;
    idle_out_pct = 0;
    wait_drained();
    done = 1;
    $display("covered %0d items (%0d resamples), %0d results checked",
             accepted, resamples, results);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

FILE: sim.f
hdl/lgts_pkg.sv
hdl/lgts_cell.sv
hdl/lda_gibbs_topic_sampler_core.sv
tb/tb_lda_gibbs_topic_sampler_core.sv
